@@ rtl/core/tgad_pkg.sv @@
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants of the TGA run-length pixel decoder: field
// widths, register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tgad_pkg;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 7;
	localparam int REPEAT_BIT = 7;
	localparam int X_W       = 12;
	localparam int ROW_W     = 12;
	localparam int LEN_W     = 8;
	localparam int PIX_W     = 32;
	localparam int CFG_W     = 13;
	localparam int BPP_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int BIP_W     = 2;

	// smallest supported sizes
	localparam int MIN_WIDTH  = 3;
	localparam int MIN_HEIGHT = 1;
	localparam int MIN_BPP    = 1;

	// register reset values
	localparam int WIDTH_RESET  = 64;
	localparam int HEIGHT_RESET = 64;
	localparam int BPP_RESET    = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE      = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT,
		ST_OVR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic halt;
		logic take_packet;
		logic accum;
		logic start_run;
		logic put_seg;
		logic put_ovr;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cfg_write;
		logic action;
		logic stopped;
		logic left_zero;
		logic packet;
		logic too_long;
		logic pix_full;
		logic run_empty;
		logic out_free;
		logic seg_final;
	} dp_status_t;

endpackage

@@ rtl/core/tgad_byte_if.sv @@
// ----------------------------------------------------------------------------
// tgad_byte_if
// Input channel: one pixel-stream byte or a frame start per word.
// ----------------------------------------------------------------------------
interface tgad_byte_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [tgad_pkg::BYTE_W-1:0]      byte_value;

	modport source (output valid, action, byte_value, input ready);
	modport sink (input valid, action, byte_value, output ready);
endinterface

@@ rtl/core/tgad_seg_if.sv @@
// ----------------------------------------------------------------------------
// tgad_seg_if
// Output channel: one row segment (or overrun report) per word.
// ----------------------------------------------------------------------------
interface tgad_seg_if;
	logic                            valid;
	logic                            ready;
	logic [tgad_pkg::X_W-1:0]        x_start;
	logic [tgad_pkg::ROW_W-1:0]      row;
	logic [tgad_pkg::LEN_W-1:0]      seg_length;
	logic [tgad_pkg::PIX_W-1:0]      pixel_value;
	logic                            is_last;
	logic                            frame_done;
	logic                            overrun;

	modport source (output valid, x_start, row, seg_length, pixel_value, is_last,
		frame_done, overrun, input ready);
	modport sink (input valid, x_start, row, seg_length, pixel_value, is_last,
		frame_done, overrun, output ready);
endinterface

@@ rtl/core/tgad_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgad_ctrl
// Controller: sequences accept, decode of one word, and segment or overrun output.
// ----------------------------------------------------------------------------
module tgad_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tgad_pkg::dp_status_t   st,
	output tgad_pkg::ctrl_cmd_t    cmd
);

	tgad_pkg::state_t state_q;
	tgad_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tgad_pkg::ST_IDLE: begin
				if (in_valid && !st.cfg_write) begin
					state_d = tgad_pkg::ST_EXEC;
				end
			end
			tgad_pkg::ST_EXEC: begin
				if (st.action || st.stopped || st.left_zero) begin
					state_d = tgad_pkg::ST_IDLE;
				end else if (st.packet) begin
					state_d = st.too_long ? tgad_pkg::ST_OVR : tgad_pkg::ST_IDLE;
				end else if (st.pix_full && !st.run_empty) begin
					state_d = tgad_pkg::ST_EMIT;
				end else begin
					state_d = tgad_pkg::ST_IDLE;
				end
			end
			tgad_pkg::ST_EMIT: begin
				if (st.out_free && st.seg_final) begin
					state_d = tgad_pkg::ST_IDLE;
				end
			end
			tgad_pkg::ST_OVR: begin
				if (st.out_free) begin
					state_d = tgad_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tgad_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tgad_pkg::ST_IDLE: begin
				in_ready = !st.cfg_write;
				cmd.load = in_valid && !st.cfg_write;
			end
			tgad_pkg::ST_EXEC: begin
				if (st.action) begin
					cmd.clear = 1'b1;
				end else if (st.stopped || st.left_zero) begin
					cmd.halt = 1'b1;
				end else if (st.packet) begin
					cmd.take_packet = !st.too_long;
				end else begin
					cmd.accum     = 1'b1;
					cmd.start_run = st.pix_full;
				end
			end
			tgad_pkg::ST_EMIT: begin
				cmd.put_seg = st.out_free;
			end
			tgad_pkg::ST_OVR: begin
				cmd.put_ovr = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/tgad_dp.sv @@
// ----------------------------------------------------------------------------
// tgad_dp
// Datapath: configuration registers, packet and pixel assembly, frame
// position counters, segment splitting and the output register.
// ----------------------------------------------------------------------------
module tgad_dp #(
	parameter int MAX_WIDTH       = 4096,
	parameter int MAX_HEIGHT      = 4096,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgad_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_action,
	input  logic [tgad_pkg::BYTE_W-1:0]         in_byte,
	input  tgad_pkg::ctrl_cmd_t                 cmd,
	output tgad_pkg::dp_status_t                st,
	tgad_seg_if.source                          seg_out
);

	localparam int     CW      = $clog2(MAX_WIDTH + 1);
	localparam int     HW      = $clog2(MAX_HEIGHT + 1);
	localparam longint MAX_PIX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam int     PD_W    = $clog2(MAX_PIX + 1);
	localparam int     LW      = (PD_W > tgad_pkg::LEN_W + 1) ? PD_W : tgad_pkg::LEN_W + 1;
	localparam int     WCMP    = (CW > tgad_pkg::CFG_W) ? CW : tgad_pkg::CFG_W;
	localparam int     HCMP    = (HW > tgad_pkg::CFG_W) ? HW : tgad_pkg::CFG_W;
	localparam int     SW      = (CW > tgad_pkg::LEN_W) ? CW : tgad_pkg::LEN_W;
	localparam int     RST_H   = (tgad_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
		tgad_pkg::HEIGHT_RESET;
	localparam logic [tgad_pkg::ROW_W-1:0] RST_ROW = tgad_pkg::ROW_W'(RST_H - 1);

	// configuration registers
	logic [tgad_pkg::CFG_W-1:0] width_q;
	logic [tgad_pkg::CFG_W-1:0] height_q;
	logic [tgad_pkg::BPP_W-1:0] bpp_q;
	logic                       rle_q;

	// decode state
	logic                                 expect_q;
	logic [tgad_pkg::BIP_W-1:0]           bip_q;
	logic [MAX_PIXEL_BYTES-1:0][tgad_pkg::BYTE_W-1:0] pixbuf_q;
	logic [tgad_pkg::LEN_W-1:0]           run_left_q;
	logic                                 rep_q;
	logic [PD_W-1:0]                      done_q;
	logic [CW-1:0]                        col_q;
	logic [tgad_pkg::ROW_W-1:0]           row_q;
	logic                                 stopped_q;

	// latched input word and run in progress
	logic                                 action_q;
	logic [tgad_pkg::BYTE_W-1:0]          byte_q;
	logic [MAX_PIXEL_BYTES*tgad_pkg::BYTE_W-1:0] pix_run_q;
	logic [tgad_pkg::LEN_W-1:0]           n_q;
	logic [PD_W-1:0]                      left_q;
	logic [PD_W-1:0]                      total_q;

	// output register
	logic                                 out_valid_q;
	logic [tgad_pkg::X_W-1:0]             out_x_q;
	logic [tgad_pkg::ROW_W-1:0]           out_row_q;
	logic [tgad_pkg::LEN_W-1:0]           out_len_q;
	logic [tgad_pkg::PIX_W-1:0]           out_pix_q;
	logic                                 out_last_q;
	logic                                 out_done_q;
	logic                                 out_ovr_q;

	// combinational
	logic [WCMP-1:0]                      w_ext;
	logic [HCMP-1:0]                      h_ext;
	logic [CW-1:0]                        w_eff;
	logic [HW-1:0]                        h_eff;
	logic [tgad_pkg::BPP_W-1:0]           bpp_eff;
	logic [CW+HW-1:0]                     prod;
	logic                                 left_zero;
	logic [PD_W-1:0]                      left;
	logic [tgad_pkg::LEN_W-1:0]           count;
	logic                                 pix_full;
	logic [MAX_PIXEL_BYTES-1:0][tgad_pkg::BYTE_W-1:0] pix_next;
	logic [tgad_pkg::LEN_W-1:0]           n_raw;
	logic [tgad_pkg::LEN_W-1:0]           n_cl;
	logic                                 wrap0;
	logic [CW-1:0]                        col0;
	logic [tgad_pkg::ROW_W-1:0]           row0;
	logic [CW-1:0]                        room;
	logic [tgad_pkg::LEN_W-1:0]           seg;
	logic                                 seg_done;
	logic                                 row_end;
	logic [tgad_pkg::LEN_W-1:0]           n_rest;
	logic                                 out_free;

	// clamp the frame sizes
	assign w_ext = WCMP'(width_q);
	assign h_ext = HCMP'(height_q);

	always_comb begin
		if (w_ext < WCMP'(tgad_pkg::MIN_WIDTH)) begin
			w_eff = CW'(tgad_pkg::MIN_WIDTH);
		end else if (w_ext > WCMP'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(w_ext);
		end
		if (h_ext < HCMP'(tgad_pkg::MIN_HEIGHT)) begin
			h_eff = HW'(tgad_pkg::MIN_HEIGHT);
		end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(h_ext);
		end
		if (bpp_q < tgad_pkg::BPP_W'(tgad_pkg::MIN_BPP)) begin
			bpp_eff = tgad_pkg::BPP_W'(tgad_pkg::MIN_BPP);
		end else if (bpp_q > tgad_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
			bpp_eff = tgad_pkg::BPP_W'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// frame pixel count, registered
	assign prod = (CW+HW)'(w_eff) * (CW+HW)'(h_eff);

	// pixels still to write
	assign left_zero = done_q >= total_q;
	assign left      = left_zero ? '0 : total_q - done_q;

	// packet count and pixel assembly
	assign count    = tgad_pkg::LEN_W'(byte_q[tgad_pkg::COUNT_W-1:0]) + tgad_pkg::LEN_W'(1);
	assign pix_full = (tgad_pkg::BPP_W'(bip_q) + tgad_pkg::BPP_W'(1)) >= bpp_eff;

	always_comb begin
		pix_next = pixbuf_q;
		for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
			if (bip_q == tgad_pkg::BIP_W'(i)) begin
				pix_next[i] = byte_q;
			end
		end
	end

	// run length of the finished pixel, clamped to the frame
	always_comb begin
		if (rle_q && rep_q) begin
			n_raw = run_left_q;
		end else begin
			n_raw = tgad_pkg::LEN_W'(1);
		end
		if (LW'(n_raw) > LW'(left)) begin
			n_cl = tgad_pkg::LEN_W'(left);
		end else begin
			n_cl = n_raw;
		end
	end

	// next row segment
	assign wrap0 = col_q >= w_eff;
	assign col0  = wrap0 ? '0 : col_q;
	assign row0  = wrap0 ? row_q - tgad_pkg::ROW_W'(1) : row_q;
	assign room  = w_eff - col0;

	always_comb begin
		if (SW'(room) > SW'(n_q)) begin
			seg = n_q;
		end else begin
			seg = tgad_pkg::LEN_W'(room);
		end
	end

	assign seg_done = LW'(seg) == LW'(left_q);
	assign row_end  = SW'(seg) == SW'(room);
	assign n_rest   = n_q - seg;
	assign out_free = !out_valid_q || seg_out.ready;

	// status
	always_comb begin
		st           = '0;
		st.cfg_write = cfg_we;
		st.action    = action_q;
		st.stopped   = stopped_q;
		st.left_zero = left_zero;
		st.packet    = rle_q && expect_q;
		st.too_long  = LW'(count) > LW'(left);
		st.pix_full  = pix_full;
		st.run_empty = n_cl == '0;
		st.out_free  = out_free;
		st.seg_final = (n_rest == '0) || seg_done;
	end

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tgad_pkg::CFG_W'(tgad_pkg::WIDTH_RESET);
			height_q <= tgad_pkg::CFG_W'(tgad_pkg::HEIGHT_RESET);
			bpp_q    <= tgad_pkg::BPP_W'(tgad_pkg::BPP_RESET);
			rle_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tgad_pkg::REG_IMAGE_WIDTH:     width_q  <= cfg_data;
				tgad_pkg::REG_IMAGE_HEIGHT:    height_q <= cfg_data;
				tgad_pkg::REG_BYTES_PER_PIXEL: bpp_q    <= cfg_data[tgad_pkg::BPP_W-1:0];
				tgad_pkg::REG_RLE_ENABLE:      rle_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input word, frame size and run registers
	always_ff @(posedge clk) begin
		total_q <= PD_W'(prod);
		if (cmd.load) begin
			action_q <= in_action;
			byte_q   <= in_byte;
		end
		if (cmd.start_run) begin
			pix_run_q <= pix_next;
			n_q       <= n_cl;
			left_q    <= left;
		end else if (cmd.put_seg) begin
			n_q    <= n_rest;
			left_q <= left_q - PD_W'(seg);
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q   <= 1'b1;
			bip_q      <= '0;
			pixbuf_q   <= '0;
			run_left_q <= '0;
			rep_q      <= 1'b0;
			done_q     <= '0;
			col_q      <= '0;
			row_q      <= RST_ROW;
			stopped_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				expect_q   <= 1'b1;
				bip_q      <= '0;
				pixbuf_q   <= '0;
				run_left_q <= '0;
				rep_q      <= 1'b0;
				done_q     <= '0;
				col_q      <= '0;
				row_q      <= tgad_pkg::ROW_W'(h_eff - HW'(1));
				stopped_q  <= 1'b0;
			end
			if (cmd.halt || cmd.put_ovr) begin
				stopped_q <= 1'b1;
			end
			// packet header
			if (cmd.take_packet) begin
				run_left_q <= count;
				rep_q      <= byte_q[tgad_pkg::REPEAT_BIT];
				expect_q   <= 1'b0;
				bip_q      <= '0;
				pixbuf_q   <= '0;
			end
			// pixel byte
			if (cmd.accum) begin
				if (pix_full) begin
					bip_q    <= '0;
					pixbuf_q <= '0;
				end else begin
					bip_q    <= bip_q + tgad_pkg::BIP_W'(1);
					pixbuf_q <= pix_next;
				end
			end
			// run bookkeeping once the pixel is complete
			if (cmd.start_run && rle_q) begin
				if (rep_q) begin
					run_left_q <= '0;
					expect_q   <= 1'b1;
				end else begin
					if (run_left_q != '0) begin
						run_left_q <= run_left_q - tgad_pkg::LEN_W'(1);
					end
					if (run_left_q <= tgad_pkg::LEN_W'(1)) begin
						expect_q <= 1'b1;
					end
				end
			end
			// position advance per segment
			if (cmd.put_seg) begin
				done_q <= done_q + PD_W'(seg);
				if (row_end) begin
					col_q <= '0;
					row_q <= row0 - tgad_pkg::ROW_W'(1);
				end else begin
					col_q <= col0 + CW'(seg);
					row_q <= row0;
				end
				if (seg_done) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put_seg || cmd.put_ovr) begin
			out_valid_q <= 1'b1;
		end else if (seg_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.put_seg) begin
			out_x_q    <= tgad_pkg::X_W'(col0);
			out_row_q  <= row0;
			out_len_q  <= seg;
			out_pix_q  <= tgad_pkg::PIX_W'(pix_run_q);
			out_last_q <= (n_rest == '0) || seg_done;
			out_done_q <= seg_done;
			out_ovr_q  <= 1'b0;
		end else if (cmd.put_ovr) begin
			out_x_q    <= tgad_pkg::X_W'(col_q);
			out_row_q  <= row_q;
			out_len_q  <= '0;
			out_pix_q  <= '0;
			out_last_q <= 1'b1;
			out_done_q <= 1'b0;
			out_ovr_q  <= 1'b1;
		end
	end

	assign seg_out.valid       = out_valid_q;
	assign seg_out.x_start     = out_x_q;
	assign seg_out.row         = out_row_q;
	assign seg_out.seg_length  = out_len_q;
	assign seg_out.pixel_value = out_pix_q;
	assign seg_out.is_last     = out_last_q;
	assign seg_out.frame_done  = out_done_q;
	assign seg_out.overrun     = out_ovr_q;

`ifndef SYNTHESIS
	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_seg || cmd.put_ovr) |-> out_free)
		else $error("output word overwritten");

	// a segment always carries pixels
	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_seg |-> (seg != '0))
		else $error("empty row segment");

	// the segment that fills the frame stops it
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_seg && seg_done) |=> (stopped_q && out_done_q))
		else $error("frame not stopped after last pixel");

	// an overrun report is the last word and stops the frame
	a_ovr_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_ovr |=> (out_valid_q && out_ovr_q && out_last_q && stopped_q))
		else $error("overrun report malformed");
`endif

endmodule

@@ rtl/core/tga_rle_pixel_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// TGA pixel-data decoder (raw or run-length) that reports pixels as row
// segments at their bottom-up flipped destination rows.
// ----------------------------------------------------------------------------
// One input word is taken at a time. A word that completes no pixel (packet
// byte, partial pixel byte, frame start, ignored byte) is accepted and then
// decoded. A packet byte that overruns the frame is accepted, decoded and
// then sends the overrun report once the output register is free. A word
// that completes a pixel is accepted, decoded and then split into row
// segments (one for a raw pixel, one per row touched for a repeated run);
// the segment splitter in the datapath emits one segment per cycle while the
// output is not stalled, through a single output register, which also
// holds a finished word while the next input word is accepted. Input ready is
// low during a configuration write.
// Configuration registers: index 0 image_width, 1 image_height,
// 2 bytes_per_pixel, 3 rle_enable.
module tga_rle_pixel_decoder_unit #(
	parameter int MAX_WIDTH       = 4096,
	parameter int MAX_HEIGHT      = 4096,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgad_pkg::CFG_W-1:0]        cfg_data,
	tgad_byte_if.sink                         byte_in,
	tgad_seg_if.source                        seg_out
);

	tgad_pkg::ctrl_cmd_t  cmd;
	tgad_pkg::dp_status_t st;
	logic                 in_ready;

	assign byte_in.ready = in_ready;

	// controller
	tgad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_in.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	tgad_dp #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (byte_in.action),
		.in_byte   (byte_in.byte_value),
		.cmd       (cmd),
		.st        (st),
		.seg_out   (seg_out)
	);

endmodule

@@ tb/sv/tga_rle_pixel_decoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit_test
// Self-checking bench for the TGA pixel decoder. Directed and random frames
// (raw and run-length, several sizes, mid-frame size changes) are streamed in
// byte by byte while both channels stall at random. Every row segment that
// comes out is compared field by field with a behavioral decoder that tracks
// the block word by word.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 4096;
	localparam int MAX_PIXEL_BYTES = 4;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int DRAIN_CYCLES  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 9;
	localparam int HOLD_PHASE    = 4;
	localparam int MAX_REPORTS   = 40;
	localparam int MAX_RUN       = 128;
	localparam int MAX_RAW_RUN   = 6;
	localparam int ROW_MASK      = (1 << tgad_pkg::ROW_W) - 1;

	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_START = 1'b1;
	localparam logic [tgad_pkg::BYTE_W-1:0] COUNT_MASK = 8'h7f;

	typedef enum logic [1:0] {
		IDLE_SLOW_SINK,
		IDLE_SLOW_SOURCE,
		IDLE_NONE
	} idle_mode_t;

	typedef struct packed {
		logic                        action;
		logic [tgad_pkg::BYTE_W-1:0] value;
	} stream_word_t;

	typedef struct packed {
		logic [tgad_pkg::X_W-1:0]   x_start;
		logic [tgad_pkg::ROW_W-1:0] row;
		logic [tgad_pkg::LEN_W-1:0] seg_length;
		logic [tgad_pkg::PIX_W-1:0] pixel_value;
		logic                       is_last;
		logic                       frame_done;
		logic                       overrun;
	} segment_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [tgad_pkg::CFG_IDX_W-1:0] cfg_index = tgad_pkg::REG_IMAGE_WIDTH;
	logic [tgad_pkg::CFG_W-1:0]     cfg_data = '0;

	tgad_byte_if byte_ch ();
	tgad_seg_if  seg_ch ();

	tga_rle_pixel_decoder_unit #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.byte_in  (byte_ch),
		.seg_out  (seg_ch)
	);

	stream_word_t words_to_send[$];
	segment_t     expected_segs[$];

	logic       word_taken = 1'b0;
	idle_mode_t idle_mode = IDLE_SLOW_SINK;
	int         hold_requests = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         errors = 0;
	int         segs_checked = 0;
	int         cycles = 0;

	// decoder copy: registers
	logic [tgad_pkg::CFG_W-1:0] dec_width;
	logic [tgad_pkg::CFG_W-1:0] dec_height;
	logic [tgad_pkg::BPP_W-1:0] dec_bpp;
	logic                       dec_rle;

	// decoder copy: frame position and pixel assembly
	bit                         awaiting_packet;
	int unsigned                pix_bytes;
	logic [tgad_pkg::PIX_W-1:0] pix_acc;
	int unsigned                run_count;
	bit                         run_repeats;
	int unsigned                filled;
	int unsigned                col;
	int unsigned                row_now;
	bit                         halted;

	// stimulus view of the frame being generated
	int unsigned gen_bpp;
	int unsigned gen_total;
	int unsigned gen_left = 0;
	bit          gen_rle;
	bit          gen_long;

	// clock
	always #HALF_PERIOD clk = ~clk;

	function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned pixels_remaining();
		int unsigned total;
		total = clamp(32'(dec_width), tgad_pkg::MIN_WIDTH, MAX_WIDTH)
			* clamp(32'(dec_height), tgad_pkg::MIN_HEIGHT, MAX_HEIGHT);
		return (filled >= total) ? 0 : total - filled;
	endfunction

	function automatic void clear_frame();
		awaiting_packet = 1'b1;
		pix_bytes = 0;
		pix_acc = '0;
		run_count = 0;
		run_repeats = 1'b0;
		filled = 0;
		col = 0;
		row_now = (clamp(32'(dec_height), tgad_pkg::MIN_HEIGHT, MAX_HEIGHT) - 1) & ROW_MASK;
		halted = 1'b0;
	endfunction

	function automatic void apply_register(logic [tgad_pkg::CFG_IDX_W-1:0] idx,
		logic [tgad_pkg::CFG_W-1:0] data);
		case (idx)
			tgad_pkg::REG_IMAGE_WIDTH: dec_width = data;
			tgad_pkg::REG_IMAGE_HEIGHT: dec_height = data;
			tgad_pkg::REG_BYTES_PER_PIXEL: dec_bpp = data[tgad_pkg::BPP_W-1:0];
			tgad_pkg::REG_RLE_ENABLE: dec_rle = data[0];
			default: ;
		endcase
	endfunction

	// split n copies of a pixel into row segments from the current position
	function automatic void emit_segments(int unsigned n, logic [tgad_pkg::PIX_W-1:0] pix);
		int unsigned w;
		int unsigned seg;
		bit          done;
		segment_t    s;
		w = clamp(32'(dec_width), tgad_pkg::MIN_WIDTH, MAX_WIDTH);
		if (n > pixels_remaining())
			n = pixels_remaining();
		while (n > 0) begin
			if (col >= w) begin
				col = 0;
				row_now = (row_now - 1) & ROW_MASK;
			end
			seg = w - col;
			if (seg > n)
				seg = n;
			n -= seg;
			filled += seg;
			done = (pixels_remaining() == 0);
			s = '{x_start: tgad_pkg::X_W'(col), row: tgad_pkg::ROW_W'(row_now),
				seg_length: tgad_pkg::LEN_W'(seg), pixel_value: pix, is_last: 1'b0,
				frame_done: done, overrun: 1'b0};
			expected_segs.push_back(s);
			col += seg;
			if (col >= w) begin
				col = 0;
				row_now = (row_now - 1) & ROW_MASK;
			end
			if (done) begin
				halted = 1'b1;
				break;
			end
		end
	endfunction

	// expected segments for one accepted word
	function automatic void decode_word(stream_word_t wd);
		int unsigned                queued_prior;
		int unsigned                cnt;
		logic [tgad_pkg::PIX_W-1:0] pix;
		segment_t                   s;
		queued_prior = expected_segs.size();
		if (wd.action == ACT_START) begin
			clear_frame();
			return;
		end
		if (halted || pixels_remaining() == 0) begin
			halted = 1'b1;
			return;
		end
		// packet byte
		if (dec_rle && awaiting_packet) begin
			cnt = (wd.value & COUNT_MASK) + 1;
			if (cnt > pixels_remaining()) begin
				s = '{x_start: tgad_pkg::X_W'(col), row: tgad_pkg::ROW_W'(row_now),
					seg_length: '0, pixel_value: '0, is_last: 1'b1, frame_done: 1'b0,
					overrun: 1'b1};
				expected_segs.push_back(s);
				halted = 1'b1;
				return;
			end
			run_count = cnt;
			run_repeats = wd.value[tgad_pkg::REPEAT_BIT];
			awaiting_packet = 1'b0;
			pix_bytes = 0;
			pix_acc = '0;
			return;
		end
		// pixel byte
		pix_acc |= tgad_pkg::PIX_W'(wd.value) << (tgad_pkg::BYTE_W * pix_bytes);
		if (pix_bytes + 1 < clamp(32'(dec_bpp), tgad_pkg::MIN_BPP, MAX_PIXEL_BYTES)) begin
			pix_bytes++;
			return;
		end
		pix = pix_acc;
		pix_bytes = 0;
		pix_acc = '0;
		if (!dec_rle) begin
			emit_segments(1, pix);
		end else if (run_repeats) begin
			emit_segments(run_count, pix);
			run_count = 0;
			awaiting_packet = 1'b1;
		end else begin
			emit_segments(1, pix);
			if (run_count > 0)
				run_count--;
			if (run_count == 0)
				awaiting_packet = 1'b1;
		end
		if (expected_segs.size() > queued_prior) begin
			s = expected_segs.pop_back();
			s.is_last = 1'b1;
			expected_segs.push_back(s);
		end
	endfunction

	function automatic bit idle_roll(bit sink_side);
		int pct;
		case (idle_mode)
			IDLE_SLOW_SINK: pct = sink_side ? 76 : 38;
			IDLE_SLOW_SOURCE: pct = sink_side ? 38 : 76;
			default: pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic report(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [tgad_pkg::PIX_W-1:0] got,
		logic [tgad_pkg::PIX_W-1:0] want);
		if (got !== want)
			report($sformatf("segment %0d %s: got 0x%0h, expected 0x%0h",
				segs_checked, name, got, want));
	endtask

	task automatic push_word(logic action, logic [tgad_pkg::BYTE_W-1:0] value);
		words_to_send.push_back('{action: action, value: value});
	endtask

	task automatic write_reg(logic [tgad_pkg::CFG_IDX_W-1:0] idx,
		logic [tgad_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
	endtask

	// write all four registers, junk in the unused high bits
	task automatic set_frame(int unsigned w, int unsigned h, int unsigned bpp, bit rle);
		write_reg(tgad_pkg::REG_IMAGE_WIDTH, tgad_pkg::CFG_W'(w));
		write_reg(tgad_pkg::REG_IMAGE_HEIGHT, tgad_pkg::CFG_W'(h));
		write_reg(tgad_pkg::REG_BYTES_PER_PIXEL,
			(tgad_pkg::CFG_W'($urandom) << tgad_pkg::BPP_W)
			| tgad_pkg::CFG_W'(bpp[tgad_pkg::BPP_W-1:0]));
		write_reg(tgad_pkg::REG_RLE_ENABLE,
			(tgad_pkg::CFG_W'($urandom) << 1) | tgad_pkg::CFG_W'(rle));
		@(negedge clk);
		cfg_we = 1'b0;
		gen_bpp = clamp(32'(bpp[tgad_pkg::BPP_W-1:0]), tgad_pkg::MIN_BPP, MAX_PIXEL_BYTES);
		gen_total = clamp(32'(w[tgad_pkg::CFG_W-1:0]), tgad_pkg::MIN_WIDTH, MAX_WIDTH)
			* clamp(32'(h[tgad_pkg::CFG_W-1:0]), tgad_pkg::MIN_HEIGHT, MAX_HEIGHT);
		gen_rle = rle;
	endtask

	// no word queued or in flight, every segment back, block settled
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (words_to_send.size() != 0 || byte_ch.valid);
		do
			@(negedge clk);
		while (expected_segs.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed frames with random content, some noise and broken packets
	task automatic fill_random(int target);
		int          made;
		int unsigned cnt;
		int unsigned lim;
		bit          rep;
		int          r;
		made = 0;
		if ($urandom_range(0, 4) != 0) begin
			push_word(ACT_START, tgad_pkg::BYTE_W'($urandom));
			gen_left = gen_total;
		end
		if (gen_left == 0)
			gen_left = gen_total;
		while (made < target) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// frame restarted mid-stream
				push_word(ACT_START, tgad_pkg::BYTE_W'($urandom));
				gen_left = gen_total;
			end else if (r < 8) begin
				push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
			end else if (!gen_rle) begin
				repeat (gen_bpp) push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
				made += gen_bpp;
				gen_left--;
			end else if (r < 14 && gen_left < MAX_RUN) begin
				// packet longer than what is left of the frame
				cnt = $urandom_range(gen_left + 1, MAX_RUN);
				push_word(ACT_DATA, {1'($urandom), 7'(cnt - 1)});
				push_word(ACT_START, tgad_pkg::BYTE_W'($urandom));
				made++;
				gen_left = gen_total;
			end else begin
				lim = (gen_left < MAX_RUN) ? gen_left : MAX_RUN;
				r = $urandom_range(0, 2);
				if (gen_long ? r != 0 : r == 0)
					cnt = lim;
				else if ($urandom_range(0, 1))
					cnt = $urandom_range(1, (lim < 8) ? lim : 8);
				else
					cnt = $urandom_range(1, lim);
				rep = $urandom_range(0, 99) < (gen_long ? 90 : 50);
				if (!rep && cnt > MAX_RAW_RUN)
					cnt = $urandom_range(1, MAX_RAW_RUN);
				push_word(ACT_DATA, {rep, 7'(cnt - 1)});
				repeat (rep ? gen_bpp : cnt * gen_bpp)
					push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
				made += 1 + (rep ? gen_bpp : cnt * gen_bpp);
				gen_left -= cnt;
			end
			if (gen_left == 0) begin
				if ($urandom_range(0, 1))
					push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
				push_word(ACT_START, tgad_pkg::BYTE_W'($urandom));
				gen_left = gen_total;
			end
		end
	endtask

	// input driver
	always @(negedge clk) begin : feed
		stream_word_t wd;
		if (!byte_ch.valid || word_taken) begin
			if (words_to_send.size() != 0 && !idle_roll(1'b0)) begin
				wd = words_to_send.pop_front();
				byte_ch.valid <= 1'b1;
				byte_ch.action <= wd.action;
				byte_ch.byte_value <= wd.value;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// output ready, with one long hold-off on request
	always @(negedge clk) begin : drain
		if (hold_requests != hold_seen) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
		seg_ch.ready <= (hold_left == 0) && !idle_roll(1'b1);
	end

	// monitor: register writes, segment checks, expected segments per word
	always @(posedge clk) begin : watch
		segment_t got;
		segment_t want;
		word_taken <= byte_ch.valid && byte_ch.ready;
		if (cfg_we)
			apply_register(cfg_index, cfg_data);
		if (seg_ch.valid && seg_ch.ready) begin
			got = '{x_start: seg_ch.x_start, row: seg_ch.row, seg_length: seg_ch.seg_length,
				pixel_value: seg_ch.pixel_value, is_last: seg_ch.is_last,
				frame_done: seg_ch.frame_done, overrun: seg_ch.overrun};
			if (expected_segs.size() == 0) begin
				report($sformatf("unexpected segment x=%0d row=%0d len=%0d",
					got.x_start, got.row, got.seg_length));
			end else begin
				want = expected_segs.pop_front();
				check_field("x_start", tgad_pkg::PIX_W'(got.x_start),
					tgad_pkg::PIX_W'(want.x_start));
				check_field("row", tgad_pkg::PIX_W'(got.row), tgad_pkg::PIX_W'(want.row));
				check_field("seg_length", tgad_pkg::PIX_W'(got.seg_length),
					tgad_pkg::PIX_W'(want.seg_length));
				check_field("pixel_value", got.pixel_value, want.pixel_value);
				check_field("is_last", tgad_pkg::PIX_W'(got.is_last),
					tgad_pkg::PIX_W'(want.is_last));
				check_field("frame_done", tgad_pkg::PIX_W'(got.frame_done),
					tgad_pkg::PIX_W'(want.frame_done));
				check_field("overrun", tgad_pkg::PIX_W'(got.overrun),
					tgad_pkg::PIX_W'(want.overrun));
			end
			segs_checked++;
		end
		if (byte_ch.valid && byte_ch.ready)
			decode_word('{action: byte_ch.action, value: byte_ch.byte_value});
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** tga_rle_pixel_decoder_unit: FAILED **");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned bpp;
		bit          rle;
		byte_ch.valid = 1'b0;
		byte_ch.action = ACT_DATA;
		byte_ch.byte_value = '0;
		seg_ch.ready = 1'b0;
		dec_width = tgad_pkg::CFG_W'(tgad_pkg::WIDTH_RESET);
		dec_height = tgad_pkg::CFG_W'(tgad_pkg::HEIGHT_RESET);
		dec_bpp = tgad_pkg::BPP_W'(tgad_pkg::BPP_RESET);
		dec_rle = 1'b0;
		clear_frame();
		gen_long = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: one 32-bit raw pixel on the top stream row
		@(posedge clk);
		push_word(ACT_DATA, 8'h00);
		push_word(ACT_DATA, 8'hff);
		push_word(ACT_DATA, 8'h00);
		push_word(ACT_DATA, 8'hff);

		// 3x2 run-length frames: repeated and raw packets, overruns, ignored bytes
		wait_quiet();
		set_frame(3, 2, 1, 1'b1);
		@(posedge clk);
		push_word(ACT_START, 8'h00);
		push_word(ACT_DATA, 8'h82);
		push_word(ACT_DATA, 8'ha5);
		push_word(ACT_DATA, 8'h00);
		push_word(ACT_DATA, 8'h5a);
		push_word(ACT_DATA, 8'h85);
		push_word(ACT_DATA, 8'h33);
		push_word(ACT_START, 8'hff);
		push_word(ACT_DATA, 8'hff);
		push_word(ACT_START, 8'h00);
		push_word(ACT_DATA, 8'h85);
		push_word(ACT_DATA, 8'h11);

		// sizes changed mid-frame: column past the width, row below zero, frame full
		wait_quiet();
		set_frame(4, 2, 1, 1'b0);
		@(posedge clk);
		push_word(ACT_START, 8'h00);
		repeat (7) push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
		wait_quiet();
		set_frame(3, 4, 1, 1'b0);
		@(posedge clk);
		repeat (2) push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));
		wait_quiet();
		set_frame(3, 1, 1, 1'b0);
		@(posedge clk);
		push_word(ACT_DATA, tgad_pkg::BYTE_W'($urandom));

		// random phases: small frames, narrow tall frames, wide frames
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_quiet();
			case (p % 3)
				0: begin
					w = $urandom_range(3, 9);
					h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
					bpp = $urandom_range(0, 7);
					rle = $urandom_range(0, 3) != 0;
				end
				1: begin
					w = $urandom_range(0, 3);
					case ($urandom_range(0, 2))
						0: h = 4096;
						1: h = 8191;
						default: h = $urandom_range(40, 60);
					endcase
					bpp = $urandom_range(1, 2);
					rle = $urandom_range(0, 4) != 0;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: w = 4096;
						1: w = 8191;
						2: w = $urandom_range(4000, 4096);
						default: w = $urandom_range(4097, 8191);
					endcase
					h = $urandom_range(0, 2);
					bpp = $urandom_range(1, 2);
					rle = $urandom_range(0, 4) != 0;
				end
			endcase
			set_frame(w, h, bpp, rle);
			gen_long = (p % 3 == 2);
			@(posedge clk);
			idle_mode = (p < 3) ? IDLE_SLOW_SINK : (p < 6) ? IDLE_SLOW_SOURCE : IDLE_NONE;
			if (p == HOLD_PHASE)
				hold_requests++;
			fill_random(gen_long ? 35 : 10);
		end

		wait_quiet();
		if (errors == 0)
			$display("** tga_rle_pixel_decoder_unit: PASSED **");
		else
			$display("** tga_rle_pixel_decoder_unit: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/tgad_pkg.sv
rtl/core/tgad_byte_if.sv
rtl/core/tgad_seg_if.sv
rtl/core/tgad_ctrl.sv
rtl/core/tgad_dp.sv
rtl/core/tga_rle_pixel_decoder_unit.sv
tb/sv/tga_rle_pixel_decoder_unit_test.sv
